@@ design/fibonacci_mod_fast_doubling_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Fibonacci fast-doubling core
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_MOD_FAST_DOUBLING_CORE_ASSERT_SVH
`define FIBONACCI_MOD_FAST_DOUBLING_CORE_ASSERT_SVH

// Same-cycle implication.
`define FMFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmfd assertion failed");

// Next-cycle implication.
`define FMFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmfd assertion failed");

`endif

@@ design/fmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// fmfd_pkg
// Types and constants of the Fibonacci fast-doubling core.
// ----------------------------------------------------------------------------
package fmfd_pkg;

    // Width of every payload port.
    localparam int PORT_W = 31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DBL,
        S_SUB,
        S_MUL_GO,
        S_MUL_WAIT,
        S_ODD,
        S_STEP,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_EVEN,
        MUL_AA,
        MUL_BB
    } mul_sel_t;

    // Handshake between the sequencer and the modular multiplier.
    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic done;
    } mul_sts_t;

endpackage

@@ design/fmfd_mulmod.sv @@
// ----------------------------------------------------------------------------
// fmfd_mulmod
// Iterative modular multiplier: one bit of the multiplier per cycle,
// double-and-add with exact reduction against m.
// ----------------------------------------------------------------------------
module fmfd_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fmfd_pkg::mul_ctl_t     ctl,
    input  logic [MOD_BITS-1:0]    op_a,
    input  logic [MOD_BITS-1:0]    op_b,
    input  logic [MOD_BITS-1:0]    m,
    output fmfd_pkg::mul_sts_t     sts,
    output logic [MOD_BITS-1:0]    product
);

    localparam int CNT_W = $clog2(MOD_BITS + 1);
    localparam int SUM_W = MOD_BITS + 2;

    logic [MOD_BITS-1:0] acc_reg,  acc_next;
    logic [MOD_BITS-1:0] a_reg,    a_next;
    logic [MOD_BITS-1:0] b_reg,    b_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m1;
    logic [SUM_W-1:0] m2;
    logic [SUM_W-1:0] red;

    // 2*acc + bit*a stays below 3m: reduce by m or 2m.
    always_comb
    begin
        m1  = SUM_W'(m);
        m2  = SUM_W'({m, 1'b0});
        sum = SUM_W'({acc_reg, 1'b0}) + (b_reg[MOD_BITS-1] ? SUM_W'(a_reg) : '0);
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            cnt_next  = CNT_W'(MOD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = red[MOD_BITS-1:0];
            b_next   = {b_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign sts.done = done_reg;
    assign product  = acc_reg;

endmodule

@@ design/fibonacci_mod_fast_doubling_core.sv @@
// One transaction at a time; the next one can be taken the cycle after the result leaves.
// A zero modulus skips the doubling and goes straight to the result transaction.
// Each index bit costs three passes of the shared multiplier.
// Reset: asynchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
// fibonacci_mod_fast_doubling_core
// F(n) mod m and F(n+1) mod m by fast doubling over the bits of n, MSB first.
// ----------------------------------------------------------------------------
module fibonacci_mod_fast_doubling_core #(
    parameter int INDEX_BITS = 31,
    parameter int MOD_BITS   = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fmfd_pkg::PORT_W-1:0]   index_n,
    input  logic [fmfd_pkg::PORT_W-1:0]   modulus,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fmfd_pkg::PORT_W-1:0]   fib_n_mod,
    output logic [fmfd_pkg::PORT_W-1:0]   fib_next_mod
);

    localparam int IDX_EXT_W = (INDEX_BITS > fmfd_pkg::PORT_W) ? INDEX_BITS : fmfd_pkg::PORT_W;
    localparam int MOD_EXT_W = (MOD_BITS > fmfd_pkg::PORT_W) ? MOD_BITS : fmfd_pkg::PORT_W;
    localparam int CNT_W     = $clog2(INDEX_BITS + 1);
    localparam int ALU_W     = MOD_BITS + 1;

    fmfd_pkg::state_t   state_reg, state_next;
    fmfd_pkg::mul_sel_t sel_reg,   sel_next;

    logic [INDEX_BITS-1:0] n_reg,    n_next;
    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic [MOD_BITS-1:0]   m_reg,    m_next;
    logic [MOD_BITS-1:0]   a_reg,    a_next;
    logic [MOD_BITS-1:0]   b_reg,    b_next;
    logic [MOD_BITS-1:0]   t_reg,    t_next;
    logic [MOD_BITS-1:0]   even_reg, even_next;
    logic [MOD_BITS-1:0]   aa_reg,   aa_next;
    logic [MOD_BITS-1:0]   bb_reg,   bb_next;
    logic [MOD_BITS-1:0]   odd_reg,  odd_next;

    logic [IDX_EXT_W-1:0]  n_ext;
    logic [MOD_EXT_W-1:0]  m_ext;
    logic [MOD_EXT_W-1:0]  a_ext;
    logic [MOD_EXT_W-1:0]  b_ext;
    logic [INDEX_BITS-1:0] n_in;
    logic [MOD_BITS-1:0]   m_in;

    // Shared modular add/subtract.
    logic [MOD_BITS-1:0]   alu_x;
    logic [MOD_BITS-1:0]   alu_y;
    logic                  alu_sub;
    logic [ALU_W-1:0]      alu_raw;
    logic [MOD_BITS-1:0]   alu_res;

    fmfd_pkg::mul_ctl_t    mul_ctl;
    fmfd_pkg::mul_sts_t    mul_sts;
    logic [MOD_BITS-1:0]   mul_a;
    logic [MOD_BITS-1:0]   mul_b;
    logic [MOD_BITS-1:0]   mul_p;

    assign n_ext = IDX_EXT_W'(index_n);
    assign m_ext = MOD_EXT_W'(modulus);
    assign n_in  = n_ext[INDEX_BITS-1:0];
    assign m_in  = m_ext[MOD_BITS-1:0];

    always_comb
    begin
        alu_raw = '0;
        if (alu_sub)
        begin
            alu_raw = ALU_W'(alu_x) - ALU_W'(alu_y);
            if (alu_x < alu_y)
            begin
                alu_raw = alu_raw + ALU_W'(m_reg);
            end
        end
        else
        begin
            alu_raw = ALU_W'(alu_x) + ALU_W'(alu_y);
            if (alu_raw >= ALU_W'(m_reg))
            begin
                alu_raw = alu_raw - ALU_W'(m_reg);
            end
        end
        alu_res = alu_raw[MOD_BITS-1:0];
    end

    always_comb
    begin
        case (sel_reg)
            fmfd_pkg::MUL_AA:
            begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
            fmfd_pkg::MUL_BB:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = a_reg;
                mul_b = t_reg;
            end
        endcase
    end

    fmfd_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .m       (m_reg),
        .sts     (mul_sts),
        .product (mul_p)
    );

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        m_next        = m_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        t_next        = t_reg;
        even_next     = even_reg;
        aa_next       = aa_reg;
        bb_next       = bb_reg;
        odd_next      = odd_reg;
        alu_x         = b_reg;
        alu_y         = b_reg;
        alu_sub       = 1'b0;
        mul_ctl.start = 1'b0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;

        unique case (state_reg)
            fmfd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    n_next   = n_in;
                    m_next   = m_in;
                    cnt_next = CNT_W'(INDEX_BITS);
                    a_next   = '0;
                    // 1 mod m: zero when m is one
                    b_next   = (m_in == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    if (m_in == '0)
                    begin
                        b_next     = '0;
                        state_next = fmfd_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = fmfd_pkg::S_DBL;
                    end
                end
            end
            fmfd_pkg::S_DBL:
            begin
                // t = 2b
                alu_x      = b_reg;
                alu_y      = b_reg;
                t_next     = alu_res;
                state_next = fmfd_pkg::S_SUB;
            end
            fmfd_pkg::S_SUB:
            begin
                // t = 2b - a
                alu_x      = t_reg;
                alu_y      = a_reg;
                alu_sub    = 1'b1;
                t_next     = alu_res;
                sel_next   = fmfd_pkg::MUL_EVEN;
                state_next = fmfd_pkg::S_MUL_GO;
            end
            fmfd_pkg::S_MUL_GO:
            begin
                mul_ctl.start = 1'b1;
                state_next    = fmfd_pkg::S_MUL_WAIT;
            end
            fmfd_pkg::S_MUL_WAIT:
            begin
                if (mul_sts.done)
                begin
                    case (sel_reg)
                        fmfd_pkg::MUL_EVEN:
                        begin
                            even_next  = mul_p;
                            sel_next   = fmfd_pkg::MUL_AA;
                            state_next = fmfd_pkg::S_MUL_GO;
                        end
                        fmfd_pkg::MUL_AA:
                        begin
                            aa_next    = mul_p;
                            sel_next   = fmfd_pkg::MUL_BB;
                            state_next = fmfd_pkg::S_MUL_GO;
                        end
                        default:
                        begin
                            bb_next    = mul_p;
                            state_next = fmfd_pkg::S_ODD;
                        end
                    endcase
                end
            end
            fmfd_pkg::S_ODD:
            begin
                alu_x      = aa_reg;
                alu_y      = bb_reg;
                odd_next   = alu_res;
                state_next = fmfd_pkg::S_STEP;
            end
            fmfd_pkg::S_STEP:
            begin
                // set bit: advance the doubled pair by one; clear bit: keep it
                alu_x = even_reg;
                alu_y = odd_reg;
                if (n_reg[INDEX_BITS-1])
                begin
                    a_next = odd_reg;
                    b_next = alu_res;
                end
                else
                begin
                    a_next = even_reg;
                    b_next = odd_reg;
                end
                n_next   = {n_reg[INDEX_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = fmfd_pkg::S_OUT;
                end
                else
                begin
                    state_next = fmfd_pkg::S_DBL;
                end
            end
            fmfd_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = fmfd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fmfd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmfd_pkg::S_IDLE;
            sel_reg   <= fmfd_pkg::MUL_EVEN;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        m_reg    <= m_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        t_reg    <= t_next;
        even_reg <= even_next;
        aa_reg   <= aa_next;
        bb_reg   <= bb_next;
        odd_reg  <= odd_next;
    end

    assign a_ext        = MOD_EXT_W'(a_reg);
    assign b_ext        = MOD_EXT_W'(b_reg);
    assign fib_n_mod    = a_ext[fmfd_pkg::PORT_W-1:0];
    assign fib_next_mod = b_ext[fmfd_pkg::PORT_W-1:0];

endmodule

@@ design/fmfd_checker.sv @@
// ----------------------------------------------------------------------------
// fmfd_checker
// Port-level checks of the Fibonacci fast-doubling core, bound to the top.
// ----------------------------------------------------------------------------
`include "fibonacci_mod_fast_doubling_core_assert.svh"

module fmfd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [fmfd_pkg::PORT_W-1:0]   index_n,
    input logic [fmfd_pkg::PORT_W-1:0]   modulus,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [fmfd_pkg::PORT_W-1:0]   fib_n_mod,
    input logic [fmfd_pkg::PORT_W-1:0]   fib_next_mod
);

    // A stalled result holds its value.
    `FMFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(fib_n_mod) && $stable(fib_next_mod))

    // No new transaction is taken while a result is pending.
    `FMFD_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)

    // Busy right after an input transaction.
    `FMFD_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

    // Ready again once the result is taken.
    `FMFD_ASSERT_NXT(a_ready_after_out, clk, rst_n, out_valid && out_ready, in_ready && !out_valid)

endmodule

bind fibonacci_mod_fast_doubling_core fmfd_checker u_fmfd_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for fibonacci_mod_fast_doubling_core
// Drives (index, modulus) transactions through a table of directed cases and
// then random ones. Both handshake sides stall at random. Every result is scored
// against typed values or a local fast-doubling model of F(n), F(n+1) mod m.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PORT_W       = fmfd_pkg::PORT_W;
    localparam int RAND_ITEMS   = 119;
    localparam int DIR_ITEMS    = 21;
    localparam int TOTAL_ITEMS  = DIR_ITEMS + RAND_ITEMS;
    // One index bit costs three multiplier passes plus overhead.
    localparam int DRAIN_CYCLES = 31 * (3 * 31 + 10) + 100;
    localparam int CYCLE_LIMIT  = 4000000;

    localparam logic [PORT_W-1:0] MAX_VAL = {PORT_W{1'b1}};

    typedef struct packed {
        logic [PORT_W-1:0] fn;
        logic [PORT_W-1:0] fn1;
    } fib_pair_t;

    typedef struct packed {
        logic [PORT_W-1:0] n;
        logic [PORT_W-1:0] m;
        logic              fixed_exp;
        logic [PORT_W-1:0] fn;
        logic [PORT_W-1:0] fn1;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [PORT_W-1:0] index_n;
    logic [PORT_W-1:0] modulus;
    logic              out_valid;
    logic              out_ready;
    logic [PORT_W-1:0] fib_n_mod;
    logic [PORT_W-1:0] fib_next_mod;

    fib_pair_t expected_pairs[$];
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;

    // Expected values are typed in only where they are obvious.
    dir_row_t directed_rows [DIR_ITEMS] = '{
        '{31'd0,           MAX_VAL,         1'b1, 31'd0,  31'd1},
        '{31'd0,           31'd1,           1'b1, 31'd0,  31'd0},
        '{31'd0,           31'd0,           1'b1, 31'd0,  31'd0},
        '{31'd5,           31'd0,           1'b1, 31'd0,  31'd0},
        '{MAX_VAL,         31'd0,           1'b1, 31'd0,  31'd0},
        '{31'd1,           31'd1,           1'b1, 31'd0,  31'd0},
        '{MAX_VAL,         31'd1,           1'b1, 31'd0,  31'd0},
        '{31'd1,           MAX_VAL,         1'b1, 31'd1,  31'd1},
        '{31'd2,           MAX_VAL,         1'b1, 31'd1,  31'd2},
        '{31'd3,           MAX_VAL,         1'b1, 31'd2,  31'd3},
        '{31'd10,          31'd1000,        1'b1, 31'd55, 31'd89},
        '{31'd1,           31'd2,           1'b1, 31'd1,  31'd1},
        '{31'd0,           31'd2,           1'b1, 31'd0,  31'd1},
        '{31'd46,          MAX_VAL,         1'b0, 31'd0,  31'd0},
        '{MAX_VAL,         MAX_VAL,         1'b0, 31'd0,  31'd0},
        '{MAX_VAL,         31'd2,           1'b0, 31'd0,  31'd0},
        '{31'h4000_0000,   31'h4000_0000,   1'b0, 31'd0,  31'd0},
        '{31'h2AAA_AAAA,   31'h5555_5555,   1'b0, 31'd0,  31'd0},
        '{31'h5555_5555,   31'h2AAA_AAAA,   1'b0, 31'd0,  31'd0},
        '{31'h7FFF_FFFE,   31'h7FFF_FFFE,   1'b0, 31'd0,  31'd0},
        '{31'd12345,       31'd3,           1'b0, 31'd0,  31'd0}
    };

    fibonacci_mod_fast_doubling_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .index_n      (index_n),
        .modulus      (modulus),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fib_n_mod    (fib_n_mod),
        .fib_next_mod (fib_next_mod)
    );

    // F(n) and F(n+1) mod m, doubling over the bits of n from the top.
    function automatic fib_pair_t fib_mod_pair(input logic [PORT_W-1:0] n,
                                               input logic [PORT_W-1:0] m);
        longint unsigned mm;
        longint unsigned f_k;
        longint unsigned f_k1;
        longint unsigned twice;
        longint unsigned even;
        longint unsigned odd;
        fib_pair_t       res;
        mm = 64'(m);
        res.fn  = '0;
        res.fn1 = '0;
        if (mm == 0)
        begin
            return res;
        end
        f_k  = 0;
        f_k1 = 1 % mm;
        for (int i = PORT_W - 1; i >= 0; i--)
        begin
            twice = (2 * f_k1 + mm - f_k) % mm;
            even  = (f_k * twice) % mm;
            odd   = (f_k * f_k + f_k1 * f_k1) % mm;
            if (n[i])
            begin
                f_k  = odd;
                f_k1 = (even + odd) % mm;
            end
            else
            begin
                f_k  = even;
                f_k1 = odd;
            end
        end
        res.fn  = f_k[PORT_W-1:0];
        res.fn1 = f_k1[PORT_W-1:0];
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout with %0d results outstanding", $time, expected_pairs.size());
        $display("FAIL fibonacci_mod_fast_doubling_core");
        $finish;
    end

    // Receiver: drop ready at random according to the current phase.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Score each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        fib_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                $display("%0t: unexpected result fib_n_mod %0d fib_next_mod %0d",
                         $time, fib_n_mod, fib_next_mod);
                errors++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (fib_n_mod !== want.fn)
                begin
                    $display("%0t: fib_n_mod expected %0d actual %0d",
                             $time, want.fn, fib_n_mod);
                    errors++;
                end
                if (fib_next_mod !== want.fn1)
                begin
                    $display("%0t: fib_next_mod expected %0d actual %0d",
                             $time, want.fn1, fib_next_mod);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [PORT_W-1:0] n_val;
        logic [PORT_W-1:0] m_val;
        fib_pair_t         want;
        int                pick;
        errors        = 0;
        send_idle_pct = 25;
        recv_idle_pct = 71;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        index_n  <= '0;
        modulus  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < TOTAL_ITEMS; k++)
        begin
            // Swap the stall weights after a third, then stop stalling.
            if (k < TOTAL_ITEMS / 3)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 71;
            end
            else if (k < 2 * TOTAL_ITEMS / 3)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (k < DIR_ITEMS)
            begin
                n_val = directed_rows[k].n;
                m_val = directed_rows[k].m;
                if (directed_rows[k].fixed_exp)
                begin
                    want.fn  = directed_rows[k].fn;
                    want.fn1 = directed_rows[k].fn1;
                end
                else
                begin
                    want = fib_mod_pair(n_val, m_val);
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    n_val = PORT_W'($urandom());
                else if (pick < 90)
                    n_val = PORT_W'($urandom_range(0, 100));
                else
                    n_val = MAX_VAL - PORT_W'($urandom_range(0, 3));
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    m_val = PORT_W'($urandom());
                else if (pick < 80)
                    m_val = PORT_W'($urandom_range(1, 1000));
                else if (pick < 90)
                    m_val = PORT_W'($urandom_range(0, 2));
                else
                    m_val = MAX_VAL - PORT_W'($urandom_range(0, 15));
                want = fib_mod_pair(n_val, m_val);
            end

            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            index_n  <= n_val;
            modulus  <= m_val;
            do
                @(posedge clk);
            while (!in_ready);
            expected_pairs.push_back(want);
        end
        in_valid <= 1'b0;

        while (expected_pairs.size() != 0)
            @(posedge clk);
        // Hold a while longer to catch stray results.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS fibonacci_mod_fast_doubling_core");
        else
            $display("FAIL fibonacci_mod_fast_doubling_core");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/fmfd_pkg.sv
design/fmfd_mulmod.sv
design/fibonacci_mod_fast_doubling_core.sv
design/fmfd_checker.sv
bench/testbench.sv
